>>> hw/rtl/versioned_delta_resequencer_core_defines.svh
// Assertion macros for the versioned delta resequencer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef VERSIONED_DELTA_RESEQUENCER_CORE_DEFINES_SVH
`define VERSIONED_DELTA_RESEQUENCER_CORE_DEFINES_SVH
`ifndef SYNTH
`define VDR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vdr assertion failed");
`define VDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vdr assertion failed");
`else
`define VDR_ASSERT_SAME(label, clk, rst, ante, cons)
`define VDR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/vdr_pkg.sv
// Shared types and constants for the versioned delta resequencer.
// No dependencies.
package vdr_pkg;

  localparam int ENTITY_COUNT_DEF = 64;
  localparam int WINDOW           = 16;
  localparam int WIN_BITS         = $clog2(WINDOW);
  localparam logic [15:0] NACK_INTERVAL_RST = 16'd200;

  localparam logic KIND_APPLY = 1'b0;
  localparam logic KIND_NACK  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  entity_index;
    logic [31:0] version_number;
    logic        full_snapshot;
    logic [15:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  out_entity;
    logic [31:0] out_version;
    logic [15:0] out_payload;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       exp_ver;
    logic [31:0]       last_nack;
    logic              nack_once;
    logic [WINDOW-1:0] slot_vld;
  } ent_row_t;

  typedef struct packed {
    logic [31:0] ver;
    logic [15:0] pay;
  } slot_row_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic slot_rd;
    logic step;
    logic flush;
    logic wb;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic in_go;
    logic is_full;
    logic is_old;
    logic is_eq;
    logic nack;
    logic hit;
    logic out_free;
    logic clr_done;
  } status_t;

endpackage

>>> hw/rtl/vdr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/vdr_ctrl.sv
// Sequencing state machine of the resequencer.
// Depends on vdr_pkg (cmd_t, status_t).
module vdr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vdr_pkg::status_t st,
  output vdr_pkg::cmd_t    cmd
);
  import vdr_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_SRD    = 7'b0001000,
    S_SCHK   = 7'b0010000,
    S_FLUSH  = 7'b0100000,
    S_WB     = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && st.in_go) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (st.is_full) begin
          state_next = S_FLUSH;
        end else if (st.is_old) begin
          state_next = S_IDLE;
        end else if (st.is_eq) begin
          state_next = S_SRD;
        end else if (st.nack) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_WB;
        end
      end
      S_SRD: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_SCHK;
      end
      S_SCHK: begin
        if (st.out_free) begin
          if (st.hit) begin
            cmd.step   = 1'b1;
            state_next = S_SRD;
          end else begin
            cmd.flush  = 1'b1;
            state_next = S_WB;
          end
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hw/rtl/vdr_datapath.sv
// Datapath: entity state and slot RAMs, working registers, output beat register.
// Depends on vdr_pkg, vdr_ram and versioned_delta_resequencer_core_defines.svh.
`include "versioned_delta_resequencer_core_defines.svh"
module vdr_datapath #(
  parameter int ENTITY_COUNT = vdr_pkg::ENTITY_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  vdr_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  input  vdr_pkg::cmd_t     cmd,
  output vdr_pkg::status_t  st,
  output logic              out_valid,
  input  logic              out_ready,
  output vdr_pkg::out_item_t out_data
);
  import vdr_pkg::*;

  localparam int EW  = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
  localparam int SAW = EW + WIN_BITS;
  localparam int CW  = $clog2(ENTITY_COUNT + 1);

  in_item_t          item;
  logic [31:0]       exp_ver;
  logic [31:0]       last_nack;
  logic              nack_once;
  logic [WINDOW-1:0] slot_vld;
  logic              pend_kind;
  logic [31:0]       pend_ver;
  logic [15:0]       pend_pay;
  logic [31:0]       time_now;
  logic [15:0]       nack_interval;
  logic [CW-1:0]     clr_cnt;

  ent_row_t          ent_rdata, ent_wdata;
  slot_row_t         slot_rdata, slot_wdata;
  logic [EW-1:0]     ent_a, ent_waddr;
  logic [SAW-1:0]    slot_waddr, slot_raddr;
  logic              slot_we, is_newer, do_store, out_free;
  logic [31:0]       ahead, d_exp, d_last;
  logic              d_once;
  logic [WINDOW-1:0] d_vld, store_bit;

  assign ent_a = EW'(item.entity_index);

  always_comb begin
    is_newer   = !item.full_snapshot && (item.version_number > ent_rdata.exp_ver);
    ahead      = item.version_number - ent_rdata.exp_ver;
    do_store   = is_newer && (ahead < 32'(WINDOW));
    store_bit  = '0;
    store_bit[item.version_number[WIN_BITS-1:0]] = 1'b1;
    out_free   = !out_valid || out_ready;

    st.in_go    = !in_data.req_type && (32'(in_data.entity_index) < 32'(ENTITY_COUNT));
    st.is_full  = item.full_snapshot;
    st.is_old   = !item.full_snapshot && (item.version_number < ent_rdata.exp_ver);
    st.is_eq    = !item.full_snapshot && (item.version_number == ent_rdata.exp_ver);
    st.nack     = is_newer && (!ent_rdata.nack_once ||
                  ((time_now - ent_rdata.last_nack) > {16'd0, nack_interval}));
    st.hit      = slot_vld[exp_ver[WIN_BITS-1:0]] && (slot_rdata.ver == exp_ver);
    st.out_free = out_free;
    st.clr_done = (clr_cnt == CW'(ENTITY_COUNT - 1));

    d_exp  = ent_rdata.exp_ver;
    d_last = ent_rdata.last_nack;
    d_once = ent_rdata.nack_once;
    d_vld  = ent_rdata.slot_vld;
    if (item.full_snapshot) begin
      d_exp = item.version_number + 32'd1;
      d_vld = '0;
    end else if (st.is_eq) begin
      d_exp = item.version_number + 32'd1;
    end else begin
      if (do_store) begin
        d_vld = ent_rdata.slot_vld | store_bit;
      end
      if (st.nack) begin
        d_last = time_now;
        d_once = 1'b1;
      end
    end

    slot_we    = cmd.decide && do_store;
    slot_waddr = {ent_a, item.version_number[WIN_BITS-1:0]};
    slot_wdata = '{ver: item.version_number, pay: item.payload_handle};
    slot_raddr = {ent_a, exp_ver[WIN_BITS-1:0]};

    ent_waddr  = cmd.clr_wr ? clr_cnt[EW-1:0] : ent_a;
    ent_wdata  = cmd.clr_wr ? ent_row_t'('0) :
                 ent_row_t'{exp_ver: exp_ver, last_nack: last_nack,
                            nack_once: nack_once, slot_vld: slot_vld};
  end

  vdr_ram #(.WIDTH($bits(ent_row_t)), .DEPTH(ENTITY_COUNT)) u_ent_ram (
    .clk   (clk),
    .we    (cmd.wb || cmd.clr_wr),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (cmd.accept),
    .raddr (EW'(in_data.entity_index)),
    .rdata (ent_rdata)
  );

  vdr_ram #(.WIDTH($bits(slot_row_t)), .DEPTH(ENTITY_COUNT * WINDOW)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.slot_rd),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.decide) begin
      exp_ver   <= d_exp;
      last_nack <= d_last;
      nack_once <= d_once;
      slot_vld  <= d_vld;
      pend_kind <= st.nack && !item.full_snapshot ? KIND_NACK : KIND_APPLY;
      pend_ver  <= (st.nack && !item.full_snapshot) ? ent_rdata.exp_ver : item.version_number;
      pend_pay  <= (st.nack && !item.full_snapshot) ? 16'd0 : item.payload_handle;
    end else if (cmd.step) begin
      exp_ver   <= exp_ver + 32'd1;
      slot_vld[exp_ver[WIN_BITS-1:0]] <= 1'b0;
      pend_kind <= KIND_APPLY;
      pend_ver  <= exp_ver;
      pend_pay  <= slot_rdata.pay;
    end
    if (cmd.flush || cmd.step) begin
      out_data <= '{result_kind: pend_kind, out_entity: item.entity_index,
                    out_version: pend_ver, out_payload: pend_pay,
                    last_of_run: cmd.flush};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      time_now      <= '0;
      nack_interval <= NACK_INTERVAL_RST;
      clr_cnt       <= '0;
    end else begin
      if (cmd.flush || cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept && in_data.req_type) begin
        time_now <= time_now + 32'd1;
      end
      if (cfg_valid) begin
        nack_interval <= cfg_data;
      end
      if (cmd.clr_wr && !st.clr_done) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
    end
  end

  `VDR_ASSERT_SAME(a_step_on_hit, clk, rst, cmd.step, st.hit)
  `VDR_ASSERT_SAME(a_push_when_free, clk, rst, cmd.step || cmd.flush, out_free)
  `VDR_ASSERT_NEXT(a_step_advances, clk, rst, cmd.step, exp_ver == $past(exp_ver) + 32'd1)

endmodule

>>> hw/rtl/versioned_delta_resequencer_core.sv
// Packet item, from the accepting edge through DECIDE: a stale delta returns to idle;
// a buffered delta with no result goes to WB; a full snapshot or NACK goes to FLUSH,
// where the beat is registered, then WB; an in-order delta goes through SRD and SCHK,
// again per drained slot (slot RAM read, then compare), then WB. Output stalls hold
// the item in place. Tick items do not leave idle. Reset: a clearing pass zeroes the
// entity RAM; no items taken. Depends on vdr_pkg, vdr_ctrl, vdr_datapath, vdr_ram.
module versioned_delta_resequencer_core #(
  parameter int ENTITY_COUNT = vdr_pkg::ENTITY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vdr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vdr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import vdr_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  vdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  vdr_datapath #(.ENTITY_COUNT(ENTITY_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
